@@ rtl/itoa_pkg.sv @@
// itoa_pkg: shared types, constants and helper functions for the integer to text converter
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W       = 32;
    localparam int RADIX_W       = 5;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int MAX_DIGITS    = 32;
    localparam int DIGIT_IDX_W   = $clog2(MAX_DIGITS);
    localparam int DIGIT_CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [RADIX_W-1:0]        radix;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
    } out_t;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic [RADIX_W-1:0] radix;
        logic               negative;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT,
        ST_TERM
    } back_state_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        r = raw;
        if (r < RADIX_MIN) begin
            r = RADIX_MIN;
        end
        if (r > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] off;
        if (d < DECIMAL_LIMIT) begin
            return CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end
        off = d - DECIMAL_LIMIT;
        return CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, off};
    endfunction

endpackage

`default_nettype wire

@@ rtl/itoa_front.sv @@
// itoa_front: input stage, clamps the radix and splits the value into sign and magnitude
// depends on itoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module itoa_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire itoa_pkg::in_t   s_data,
    output logic                 job_valid,
    input  wire logic            job_ready,
    output itoa_pkg::job_t       job
);

    logic           job_valid_reg;
    logic           job_valid_next;
    itoa_pkg::job_t job_reg;
    itoa_pkg::job_t job_next;
    logic           accept;

    assign s_ready   = !job_valid_reg || job_ready;
    assign accept    = s_valid && s_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb begin
        job_next.negative = s_data.value[itoa_pkg::VALUE_W-1];
        job_next.mag      = job_next.negative ? (itoa_pkg::VALUE_W'(0) - s_data.value)
                                              : s_data.value;
        job_next.radix    = itoa_pkg::clamp_radix(s_data.radix);
        job_valid_next    = accept ? 1'b1 : (job_ready ? 1'b0 : job_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job_next;
        end
    end

    // held job never carries an out-of-range radix
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg |-> (job_reg.radix >= itoa_pkg::RADIX_MIN &&
                           job_reg.radix <= itoa_pkg::RADIX_MAX))
        else $error("front job radix out of range");

    // sign flag agrees with the magnitude on a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (job_reg.negative || !job_reg.mag[itoa_pkg::VALUE_W-1] ||
                    job_reg.mag == {1'b1, {(itoa_pkg::VALUE_W-1){1'b0}}}) || !job_valid_reg)
        else $error("front magnitude inconsistent with sign");

    // a stalled job is not overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid_reg && !job_ready) |-> !accept)
        else $error("front overwrote a pending job");

endmodule

`default_nettype wire

@@ rtl/itoa_queue.sv @@
// itoa_queue: short job queue between the front and back stages
// depends on itoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module itoa_queue #(
    parameter int DEPTH = itoa_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire itoa_pkg::job_t  push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output itoa_pkg::job_t       pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itoa_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // pointers meet exactly when the queue is empty or full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg == rd_ptr_reg) == (count_reg == '0 || count_reg == CNT_W'(DEPTH)))
        else $error("queue pointers and count disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

@@ rtl/itoa_back.sv @@
// itoa_back: digit extraction by iterative division, digit stack and output register
// depends on itoa_pkg
`timescale 1ns / 1ps
`default_nettype none

module itoa_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            job_valid,
    output logic                 job_ready,
    input  wire itoa_pkg::job_t  job,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output itoa_pkg::out_t       m_data
);

    localparam int VW = itoa_pkg::VALUE_W;
    localparam int BW = itoa_pkg::BITS_PER_STEP;
    localparam int DW = itoa_pkg::DIGIT_W;

    itoa_pkg::back_state_t           state_reg;
    itoa_pkg::back_state_t           state_next;
    logic [VW-1:0]                   div_reg;
    logic [VW-1:0]                   div_next;
    logic [DW-1:0]                   rem_reg;
    logic [DW-1:0]                   rem_next;
    logic [itoa_pkg::STEP_W-1:0]     step_reg;
    logic [itoa_pkg::STEP_W-1:0]     step_next;
    logic [itoa_pkg::RADIX_W-1:0]    radix_reg;
    logic [itoa_pkg::RADIX_W-1:0]    radix_next;
    logic                            neg_reg;
    logic                            neg_next;
    logic [itoa_pkg::DIGIT_CNT_W-1:0] ndig_reg;
    logic [itoa_pkg::DIGIT_CNT_W-1:0] ndig_next;
    logic [DW-1:0]                   stack [itoa_pkg::MAX_DIGITS];
    logic                            push_digit;
    logic [itoa_pkg::DIGIT_IDX_W-1:0] rd_idx;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    itoa_pkg::out_t                  m_data_reg;
    itoa_pkg::out_t                  out_data;
    logic                            out_load;
    logic                            out_free;

    // one chunk of restoring division
    logic [VW-1:0]                   div_step;
    logic [DW-1:0]                   rem_step;
    logic [BW-1:0]                   qbits;
    logic [DW:0]                     trial;

    assign out_free = !m_valid_reg || m_ready;
    assign rd_idx   = itoa_pkg::DIGIT_IDX_W'(ndig_reg - itoa_pkg::DIGIT_CNT_W'(1));
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        rem_step = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < BW; i++) begin
            trial = {rem_step, div_reg[VW-1-i]};
            if (trial >= radix_reg) begin
                trial        = trial - radix_reg;
                qbits[BW-1-i] = 1'b1;
            end
            rem_step = trial[DW-1:0];
        end
        div_step = {div_reg[VW-BW-1:0], qbits};
    end

    always_comb begin
        state_next     = state_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        ndig_next      = ndig_reg;
        job_ready      = 1'b0;
        push_digit     = 1'b0;
        out_load       = 1'b0;
        out_data.text_char = itoa_pkg::CHAR_NUL;
        out_data.last      = 1'b0;
        unique case (state_reg)
            itoa_pkg::ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    div_next   = job.mag;
                    radix_next = job.radix;
                    neg_next   = job.negative;
                    rem_next   = '0;
                    step_next  = '0;
                    ndig_next  = '0;
                    state_next = itoa_pkg::ST_DIVIDE;
                end
            end
            itoa_pkg::ST_DIVIDE: begin
                div_next  = div_step;
                rem_next  = rem_step;
                step_next = step_reg + itoa_pkg::STEP_W'(1);
                if (step_reg == itoa_pkg::STEP_W'(itoa_pkg::DIV_STEPS - 1)) begin
                    push_digit = 1'b1;
                    ndig_next  = ndig_reg + itoa_pkg::DIGIT_CNT_W'(1);
                    rem_next   = '0;
                    step_next  = '0;
                    if (div_step == '0) begin
                        state_next = neg_reg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
                    end
                end
            end
            itoa_pkg::ST_SIGN: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_data.text_char = itoa_pkg::CHAR_MINUS;
                    state_next         = itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_data.text_char = itoa_pkg::digit_char(stack[rd_idx]);
                    ndig_next          = ndig_reg - itoa_pkg::DIGIT_CNT_W'(1);
                    if (ndig_reg == itoa_pkg::DIGIT_CNT_W'(1)) begin
                        state_next = itoa_pkg::ST_TERM;
                    end
                end
            end
            itoa_pkg::ST_TERM: begin
                if (out_free) begin
                    out_load           = 1'b1;
                    out_data.text_char = itoa_pkg::CHAR_NUL;
                    out_data.last      = 1'b1;
                    state_next         = itoa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = itoa_pkg::ST_IDLE;
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= itoa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        radix_reg <= radix_next;
        neg_reg   <= neg_next;
        ndig_reg  <= ndig_next;
        if (out_load) begin
            m_data_reg <= out_data;
        end
        if (push_digit) begin
            stack[ndig_reg[itoa_pkg::DIGIT_IDX_W-1:0]] <= rem_step;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itoa_pkg::ST_DIVIDE) |-> ndig_reg < itoa_pkg::DIGIT_CNT_W'(itoa_pkg::MAX_DIGITS))
        else $error("digit stack overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itoa_pkg::ST_EMIT || state_reg == itoa_pkg::ST_SIGN)
            |-> ndig_reg != '0)
        else $error("emitting with an empty digit stack");

    // running remainder stays below the radix
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itoa_pkg::ST_DIVIDE) |-> {1'b0, rem_reg} < radix_reg)
        else $error("division remainder not below radix");

    // terminator transfer ends the item and returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == itoa_pkg::ST_TERM && out_free)
            |=> (state_reg == itoa_pkg::ST_IDLE && m_valid_reg && m_data_reg.last))
        else $error("terminator not issued on leaving the item");

endmodule

`default_nettype wire

@@ rtl/integer_to_ascii_radix.sv @@
// integer_to_ascii_radix: signed 32-bit integer to ASCII text, radix 2 to 16
// top level; depends on itoa_pkg, itoa_front, itoa_queue, itoa_back
//
// usage:
//   s_valid/s_ready/s_data carry one value and radix per transfer; the radix is
//   clamped to 2..16. m_valid/m_ready/m_data return the text one character per
//   transfer, most significant first: '-' when negative, digits 0-9/A-F, then a
//   NUL with last set. zero gives "0"; the most negative value converts as 2^31.
//   timing: the front register and job queue take new items while the back end
//   converts. the back end handles one item at a time: each digit takes a full
//   division of the magnitude by the radix (8 quotient bits per cycle through
//   the remainder chain); the digits are stacked and then leave most significant
//   first behind any sign. a stalled receiver holds the output register and the
//   back end waits; the front keeps taking items until the queue and the front
//   register are full.
//   reset (aresetn low, synchronous) empties the queue and drops any item in
//   flight; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_radix #(
    parameter int QUEUE_DEPTH = itoa_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire itoa_pkg::in_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output itoa_pkg::out_t       m_data
);

    logic           front_valid;
    logic           front_ready;
    itoa_pkg::job_t front_job;
    logic           back_valid;
    logic           back_ready;
    itoa_pkg::job_t back_job;

    itoa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    itoa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    itoa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
